[rtl/tvce_pkg.sv]
// ----------------------------------------------------------------------------
// tvce_pkg
// Shared constants, opcodes, result kinds and the quarter-wave sine table of
// the turtle vector command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tvce_pkg;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int OP_W     = 4;
   localparam int AMOUNT_W = 16;
   localparam int KIND_W   = 2;
   localparam int COORD_W  = 16;
   localparam int HEAD_W   = 9;
   localparam int POS_W    = 32;
   localparam int ROM_W    = 18;   // signed, holds +/-65536

   localparam logic [OP_W-1:0] OP_FWD     = 4'd0;
   localparam logic [OP_W-1:0] OP_BACK    = 4'd1;
   localparam logic [OP_W-1:0] OP_LEFT    = 4'd2;
   localparam logic [OP_W-1:0] OP_RIGHT   = 4'd3;
   localparam logic [OP_W-1:0] OP_HOME    = 4'd4;
   localparam logic [OP_W-1:0] OP_CLEAN   = 4'd5;
   localparam logic [OP_W-1:0] OP_CLRSCR  = 4'd6;
   localparam logic [OP_W-1:0] OP_PENUP   = 4'd7;
   localparam logic [OP_W-1:0] OP_PENDOWN = 4'd8;

   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
   localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
   localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
   localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

   // turn reduction mod 360: operand offset by a multiple of 360 to stay
   // positive, then remainder from the fraction of a reciprocal product
   localparam int TURN_VAL_W     = 17;
   localparam int TURN_FRAC_BITS = 26;
   localparam int TURN_PROD_W    = TURN_FRAC_BITS + HEAD_W;
   localparam logic [TURN_VAL_W-1:0] TURN_OFFSET = 17'd33120;     // 92 * 360
   localparam logic [17:0]           TURN_RECIP  = 18'd186414;    // ceil(2^26/360)

   localparam logic [16:0] SINE_ROM [0:90] = '{
      17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
      17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
      17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
      17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
      17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
      17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
      17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
      17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
      17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
      17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
      17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
      17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
      17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

   // sine of a heading in 0..359, Q1.16
   function automatic logic signed [ROM_W-1:0] sine_of(input logic [HEAD_W-1:0] h);
      logic [6:0] idx;
      logic       neg;
      logic signed [ROM_W-1:0] mag;
      if (h <= DEG_90) begin
         idx = 7'(h);
         neg = 1'b0;
      end else if (h <= DEG_180) begin
         idx = 7'(DEG_180 - h);
         neg = 1'b0;
      end else if (h <= DEG_270) begin
         idx = 7'(h - DEG_180);
         neg = 1'b1;
      end else begin
         idx = 7'(DEG_360 - h);
         neg = 1'b1;
      end
      mag = $signed({1'b0, SINE_ROM[idx]});
      return neg ? -mag : mag;
   endfunction

   function automatic logic signed [ROM_W-1:0] cosine_of(input logic [HEAD_W-1:0] h);
      return sine_of((h >= DEG_270) ? (h - DEG_270) : (h + DEG_90));
   endfunction

endpackage

`default_nettype wire

[rtl/tvce_req_if.sv]
// ----------------------------------------------------------------------------
// tvce_req_if
// Command channel: valid/ready handshake carrying one turtle command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvce_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [tvce_pkg::OP_W-1:0]             op;
   logic signed [tvce_pkg::AMOUNT_W-1:0]  amount;

   modport source (output valid, output op, output amount, input ready);
   modport sink   (input valid, input op, input amount, output ready);
endinterface

`default_nettype wire

[rtl/tvce_rsp_if.sv]
// ----------------------------------------------------------------------------
// tvce_rsp_if
// Result channel: valid/ready handshake carrying one draw result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvce_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tvce_pkg::KIND_W-1:0]          kind;
   logic signed [tvce_pkg::COORD_W-1:0]  x_start;
   logic signed [tvce_pkg::COORD_W-1:0]  y_start;
   logic signed [tvce_pkg::COORD_W-1:0]  x_end;
   logic signed [tvce_pkg::COORD_W-1:0]  y_end;
   logic [tvce_pkg::HEAD_W-1:0]          heading_now;

   modport source (output valid, output kind, output x_start, output y_start,
                   output x_end, output y_end, output heading_now, input ready);
   modport sink   (input valid, input kind, input x_start, input y_start,
                   input x_end, input y_end, input heading_now, output ready);
endinterface

`default_nettype wire

[rtl/tvce_axis.sv]
// ----------------------------------------------------------------------------
// tvce_axis
// One axis of a move: amount times trig value, floor shift to the position
// format, saturating add, and integer parts of the old and new coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module tvce_axis #(
   parameter int FRACTION_BITS = tvce_pkg::FRACTION_BITS_DEF
) (
   input  wire logic signed [tvce_pkg::POS_W-1:0]    pos,
   input  wire logic signed [tvce_pkg::AMOUNT_W-1:0] amount,
   input  wire logic signed [tvce_pkg::ROM_W-1:0]    trig,
   input  wire logic                                 negate,
   output logic signed [tvce_pkg::POS_W-1:0]         pos_next,
   output logic signed [tvce_pkg::COORD_W-1:0]       int_old,
   output logic signed [tvce_pkg::COORD_W-1:0]       int_new
);

   localparam int PROD_W  = tvce_pkg::AMOUNT_W + tvce_pkg::ROM_W;
   localparam int DELTA_W = PROD_W + 1;
   localparam int SUM_W   = DELTA_W + 1;
   localparam int SHIFT   = 16 - FRACTION_BITS;
   localparam int ADJ_W   = tvce_pkg::POS_W + 1;

   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-64'sd2147483648);
   localparam logic signed [ADJ_W-1:0] RND     = (ADJ_W'(1) <<< FRACTION_BITS) - ADJ_W'(1);
   localparam logic signed [ADJ_W-1:0] INT_MAX = ADJ_W'(32767);
   localparam logic signed [ADJ_W-1:0] INT_MIN = -ADJ_W'(32768);

   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  step;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SUM_W-1:0]   sum;

   // integer part, truncated toward zero, saturated to 16 bits
   function automatic logic signed [tvce_pkg::COORD_W-1:0] int_part(
      input logic signed [tvce_pkg::POS_W-1:0] p);
      logic signed [ADJ_W-1:0] adj;
      logic signed [ADJ_W-1:0] q;
      adj = (p < 0) ? (ADJ_W'(p) + RND) : ADJ_W'(p);
      q   = adj >>> FRACTION_BITS;
      if (q > INT_MAX) begin
         q = INT_MAX;
      end else if (q < INT_MIN) begin
         q = INT_MIN;
      end
      return q[tvce_pkg::COORD_W-1:0];
   endfunction

   always_comb begin
      prod  = PROD_W'(amount) * PROD_W'(trig);
      step  = prod >>> SHIFT;
      delta = negate ? -DELTA_W'(step) : DELTA_W'(step);
      sum   = SUM_W'(pos) + SUM_W'(delta);
      if (sum > POS_MAX) begin
         pos_next = POS_MAX[tvce_pkg::POS_W-1:0];
      end else if (sum < POS_MIN) begin
         pos_next = POS_MIN[tvce_pkg::POS_W-1:0];
      end else begin
         pos_next = sum[tvce_pkg::POS_W-1:0];
      end
      int_old = int_part(pos);
      int_new = int_part(pos_next);
   end

endmodule

`default_nettype wire

[rtl/turtle_vector_command_engine_unit.sv]
// ----------------------------------------------------------------------------
// turtle_vector_command_engine_unit
// Turtle graphics command engine: keeps position, heading and pen, and turns
// each command item into one result item (segment, clear request or nothing).
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake       payload
//   req_bus   in    valid/ready     op, amount
//   rsp_bus   out   valid/ready     kind, x_start, y_start, x_end, y_end,
//                                   heading_now
//
// One item per cycle sustained while the result channel is not stalled; an
// item passes the command register, then the result register. The turn
// reciprocal multiply sits before the command register and the remainder
// multiply after it; the trig multiplies and saturating adds sit before the
// result register. Synchronous reset puts the turtle home, heading 0, pen
// down. A stalled result holds the result register and a full command
// register behind it; an empty command register still takes an item.
`default_nettype none

module turtle_vector_command_engine_unit #(
   parameter int SCREEN_WIDTH  = tvce_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tvce_pkg::SCREEN_HEIGHT_DEF,
   parameter int FRACTION_BITS = tvce_pkg::FRACTION_BITS_DEF
) (
   input wire logic      clock,
   input wire logic      reset,
   tvce_req_if.sink      req_bus,
   tvce_rsp_if.source    rsp_bus
);

   localparam int POS_W   = tvce_pkg::POS_W;
   localparam int HEAD_W  = tvce_pkg::HEAD_W;
   localparam int COORD_W = tvce_pkg::COORD_W;
   localparam int ROM_W   = tvce_pkg::ROM_W;

   localparam logic signed [POS_W-1:0] HOME_X = POS_W'((SCREEN_WIDTH / 2) << FRACTION_BITS);
   localparam logic signed [POS_W-1:0] HOME_Y = POS_W'((SCREEN_HEIGHT / 2) << FRACTION_BITS);
   localparam logic signed [ROM_W-1:0] COS_0  = ROM_W'(65536);

   // command register
   logic                                   cmd_valid_ff;
   logic [tvce_pkg::OP_W-1:0]              op_ff;
   logic signed [tvce_pkg::AMOUNT_W-1:0]   amount_ff;
   logic [tvce_pkg::TURN_FRAC_BITS-1:0]    frac_ff;

   // turtle state
   logic signed [POS_W-1:0]  pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]  pos_y_ff, pos_y_in;
   logic [HEAD_W-1:0]        heading_ff, heading_in;
   logic                     pen_ff, pen_in;
   logic signed [ROM_W-1:0]  sin_ff, cos_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [tvce_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic signed [COORD_W-1:0]      xs_ff, ys_ff, xe_ff, ye_ff;
   logic signed [COORD_W-1:0]      xs_in, ys_in, xe_in, ye_in;

   logic                           req_fire;
   logic                           out_free;
   logic                           cmd_fire;
   logic [tvce_pkg::TURN_VAL_W-1:0] turn_val;
   logic [34:0]                    recip_prod;
   logic [tvce_pkg::TURN_PROD_W-1:0] rem_prod;
   logic [HEAD_W-1:0]              turn_rem;
   logic [HEAD_W:0]                head_sum;
   logic                           is_move;
   logic                           is_back;
   logic signed [POS_W-1:0]        mx_pos, my_pos;
   logic signed [COORD_W-1:0]      mx_old, mx_new, my_old, my_new;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign cmd_fire      = cmd_valid_ff && out_free;
   assign req_bus.ready = !cmd_valid_ff || out_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // turn operand, offset to stay positive; right turns negate it
   always_comb begin
      if (req_bus.op == tvce_pkg::OP_RIGHT) begin
         turn_val = tvce_pkg::TURN_OFFSET - tvce_pkg::TURN_VAL_W'(req_bus.amount);
      end else begin
         turn_val = tvce_pkg::TURN_OFFSET + tvce_pkg::TURN_VAL_W'(req_bus.amount);
      end
      recip_prod = 35'(turn_val) * 35'(tvce_pkg::TURN_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_fire) begin
         cmd_valid_ff <= 1'b1;
      end else if (cmd_fire) begin
         cmd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_bus.op;
         amount_ff <= req_bus.amount;
         frac_ff   <= recip_prod[tvce_pkg::TURN_FRAC_BITS-1:0];
      end
   end

   assign is_move = (op_ff == tvce_pkg::OP_FWD) || (op_ff == tvce_pkg::OP_BACK);
   assign is_back = (op_ff == tvce_pkg::OP_BACK);

   tvce_axis #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_axis_x (
      .pos      (pos_x_ff),
      .amount   (amount_ff),
      .trig     (cos_ff),
      .negate   (is_back),
      .pos_next (mx_pos),
      .int_old  (mx_old),
      .int_new  (mx_new)
   );

   // y points down: forward subtracts the sine step
   tvce_axis #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_axis_y (
      .pos      (pos_y_ff),
      .amount   (amount_ff),
      .trig     (sin_ff),
      .negate   (!is_back),
      .pos_next (my_pos),
      .int_old  (my_old),
      .int_new  (my_new)
   );

   always_comb begin
      rem_prod   = tvce_pkg::TURN_PROD_W'(frac_ff) * tvce_pkg::TURN_PROD_W'(tvce_pkg::DEG_360);
      turn_rem   = rem_prod[tvce_pkg::TURN_PROD_W-1:tvce_pkg::TURN_FRAC_BITS];
      head_sum   = {1'b0, heading_ff} + {1'b0, turn_rem};

      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      pen_in     = pen_ff;
      kind_in    = tvce_pkg::KIND_NONE;
      xs_in      = '0;
      ys_in      = '0;
      xe_in      = '0;
      ye_in      = '0;

      if (is_move) begin
         pos_x_in = mx_pos;
         pos_y_in = my_pos;
         if (pen_ff) begin
            kind_in = tvce_pkg::KIND_LINE;
            xs_in   = mx_old;
            ys_in   = my_old;
            xe_in   = mx_new;
            ye_in   = my_new;
         end
      end

      case (op_ff)
         tvce_pkg::OP_LEFT, tvce_pkg::OP_RIGHT: begin
            if (head_sum >= {1'b0, tvce_pkg::DEG_360}) begin
               heading_in = HEAD_W'(head_sum - {1'b0, tvce_pkg::DEG_360});
            end else begin
               heading_in = HEAD_W'(head_sum);
            end
         end
         tvce_pkg::OP_HOME: begin
            pos_x_in   = HOME_X;
            pos_y_in   = HOME_Y;
            heading_in = '0;
         end
         tvce_pkg::OP_CLEAN: begin
            kind_in = tvce_pkg::KIND_CLEAR;
         end
         tvce_pkg::OP_CLRSCR: begin
            kind_in    = tvce_pkg::KIND_CLEAR;
            pos_x_in   = HOME_X;
            pos_y_in   = HOME_Y;
            heading_in = '0;
         end
         tvce_pkg::OP_PENUP: begin
            pen_in = 1'b0;
         end
         tvce_pkg::OP_PENDOWN: begin
            pen_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= HOME_X;
         pos_y_ff   <= HOME_Y;
         heading_ff <= '0;
         pen_ff     <= 1'b1;
         sin_ff     <= '0;
         cos_ff     <= COS_0;
      end else if (cmd_fire) begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         heading_ff <= heading_in;
         pen_ff     <= pen_in;
         sin_ff     <= tvce_pkg::sine_of(heading_in);
         cos_ff     <= tvce_pkg::cosine_of(heading_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_fire) begin
         kind_ff <= kind_in;
         xs_ff   <= xs_in;
         ys_ff   <= ys_in;
         xe_ff   <= xe_in;
         ye_ff   <= ye_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = kind_ff;
   assign rsp_bus.x_start     = xs_ff;
   assign rsp_bus.y_start     = ys_ff;
   assign rsp_bus.x_end       = xe_ff;
   assign rsp_bus.y_end       = ye_ff;
   assign rsp_bus.heading_now = heading_ff;

`ifndef SYNTHESIS
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff < tvce_pkg::DEG_360)
      else $error("heading out of range");

   a_cmd_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd_fire |=> rsp_valid_ff)
      else $error("command left without a result");

   a_no_line_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != tvce_pkg::KIND_LINE) |->
      (xs_ff == '0 && ys_ff == '0 && xe_ff == '0 && ye_ff == '0))
      else $error("coordinates on a result without a segment");

   a_penup_no_line: assert property (@(posedge clock) disable iff (reset)
      (cmd_fire && op_ff == tvce_pkg::OP_PENUP) |=> !pen_ff)
      else $error("pen still down after pen up");
`endif

endmodule

`default_nettype wire
